@@ sv/rmws_pkg.sv @@
// Shared constants for the ramped move unit with wheel synchronization.
// No dependencies; the top level and the divider import this package.
`default_nettype none

package rmws_pkg;

    // Default width to which the encoder counts are reduced.
    localparam int COUNT_WIDTH_DEF = 32;

    // Register widths.
    localparam int TGT_W  = 20;
    localparam int RAMP_W = 20;
    localparam int GAIN_W = 15;
    localparam int BASE_W = 15;
    localparam int KP_W   = 16;
    localparam int KI_W   = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd5;

    // Register values after reset.
    localparam logic [TGT_W-1:0]  TARGET_RST = 20'd4879;
    localparam logic [RAMP_W-1:0] RAMP_RST   = 20'd4010;
    localparam logic [GAIN_W-1:0] GAIN_RST   = 15'd13107;
    localparam logic [BASE_W-1:0] BASE_RST   = 15'd3277;
    localparam logic [KP_W-1:0]   KP_RST     = 16'd66;
    localparam logic [KI_W-1:0]   KI_RST     = 16'd131;

    // Drive outputs, Q1.15.
    localparam int DRIVE_W = 16;
    localparam logic [DRIVE_W-1:0] DRIVE_POS_LIM = 16'h7FFF;
    localparam logic [DRIVE_W-1:0] DRIVE_NEG_LIM = 16'h8000;

endpackage

`default_nettype wire

@@ sv/rmws_mul.sv @@
// Shared signed multiplier with a registered product.
// No package dependency; used by the ramped move top level.
`default_nettype none

module rmws_mul #(
    parameter int A_W = 34,
    parameter int B_W = 17
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [A_W-1:0]       a,
    input  wire logic signed [B_W-1:0]       b,
    output logic signed      [A_W+B_W-1:0]   p
);

    logic signed [A_W+B_W-1:0] p_reg;

    // Load a new product when the sequencer issues an operation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ sv/rmws_div.sv @@
// Iterative unsigned divider, two restoring steps per cycle.
// Depends on rmws_pkg for the divisor width.
`default_nettype none

module rmws_div
    import rmws_pkg::*;
#(
    parameter int DIVIDEND_W = 49
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DIVIDEND_W-1:0]   dividend,
    input  wire logic [RAMP_W-1:0]       divisor,
    output logic                         busy,
    output logic [DIVIDEND_W-1:0]        quotient
);

    localparam int QW    = DIVIDEND_W + (DIVIDEND_W % 2);
    localparam int STEPS = QW / 2;
    localparam int CNTW  = $clog2(STEPS + 1);

    logic [QW-1:0]     quo_reg;
    logic [QW-1:0]     quo_next;
    logic [RAMP_W-1:0] rem_reg;
    logic [RAMP_W-1:0] rem_next;
    logic [RAMP_W-1:0] den_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              busy_reg;

    logic [RAMP_W:0]   trial1;
    logic [RAMP_W:0]   trial2;
    logic [RAMP_W-1:0] rem1;
    logic              ge1;
    logic              ge2;

    // Two dependent shift-and-subtract steps for one cycle.
    always_comb
    begin
        trial1 = {rem_reg, quo_reg[QW-1]};
        ge1    = trial1 >= {1'b0, den_reg};
        rem1   = ge1 ? RAMP_W'(trial1 - {1'b0, den_reg}) : RAMP_W'(trial1);
        trial2 = {rem1, quo_reg[QW-2]};
        ge2    = trial2 >= {1'b0, den_reg};
        rem_next = ge2 ? RAMP_W'(trial2 - {1'b0, den_reg}) : RAMP_W'(trial2);
        quo_next = {quo_reg[QW-3:0], ge1, ge2};
    end

    // Step counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= QW'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[DIVIDEND_W-1:0];

endmodule

`default_nettype wire

@@ sv/ramped_move_with_wheel_sync_unit.sv @@
// Top level of the ramped move unit with PI wheel synchronization.
// Depends on rmws_pkg, rmws_mul and rmws_div.
//
// One input beat is one control tick and yields exactly one output beat. A tick of a
// running move passes through the states CHECK, DIFF, MULP, MULI, ACC, CORR, DIV, RB,
// SAT and OUT, and its result is loaded into the output register from OUT; the next
// tick can be accepted in the cycle after the load. The ramp division, which retires
// two quotient bits per cycle, sets the length of such a tick, while the three
// products share one registered multiplier. A tick that ends the move, or arrives
// after it ended, goes from CHECK straight to OUT. A stalled output register holds
// the sequencer in its last state and adds its stall cycles.
// in_stall is high from acceptance until the result is loaded into the output
// register, which then holds it for the consumer while the next tick is taken.
// cfg_ready is always high; write the registers only while no tick is in progress.
`default_nettype none

module ramped_move_with_wheel_sync_unit
    import rmws_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Tick input channel.
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   new_move,
    input  wire logic signed [31:0]     left_count,
    input  wire logic signed [31:0]     right_count,
    input  wire logic                   stop_request,
    // Drive output channel.
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [DRIVE_W-1:0]   left_drive,
    output logic signed [DRIVE_W-1:0]   right_drive,
    output logic                        move_done,
    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW  = COUNT_WIDTH;
    localparam int NW  = ((CW > 21) ? CW : 21) + 1;
    localparam int NW1 = NW + 1;
    localparam int PW  = NW + 16;
    localparam int MA  = (NW > CW + 2) ? NW : CW + 2;
    localparam int MB  = KP_W + 1;
    localparam int PRW = MA + MB;
    localparam int AW  = CW + 20;
    localparam int CRW = AW - 2;
    localparam int RPW = PW + 1;
    localparam int SW  = ((RPW > CRW) ? RPW : CRW) + 3;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIFF  = 4'd2;
    localparam logic [3:0] S_MULP  = 4'd3;
    localparam logic [3:0] S_MULI  = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_CORR  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_RB    = 4'd8;
    localparam logic [3:0] S_SAT   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // Configuration registers.
    logic [TGT_W-1:0]  target_reg;
    logic [RAMP_W-1:0] ramp_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [BASE_W-1:0] base_reg;
    logic [KP_W-1:0]   kp_reg;
    logic [KI_W-1:0]   ki_reg;

    // Move state.
    logic signed [CW-1:0] pos_reg;
    logic signed [CW-1:0] prev_left_reg;
    logic signed [CW-1:0] prev_right_reg;
    logic                 done_reg;

    // Captured tick.
    logic signed [CW-1:0] left_reg;
    logic signed [CW-1:0] right_reg;
    logic                 stop_reg;

    // Datapath registers.
    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic signed [NW-1:0]  n_reg;
    logic                  hold_reg;
    logic signed [CW+1:0]  dd_reg;
    logic signed [CW:0]    diff_reg;
    logic                  ramp_neg_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [CRW-1:0] corr_reg;
    logic signed [RPW-1:0] term_reg;
    logic signed [SW-1:0]  rb_reg;
    logic [DRIVE_W-1:0]    res_left_reg;
    logic [DRIVE_W-1:0]    res_right_reg;
    logic                  res_done_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [DRIVE_W-1:0]    out_left_reg;
    logic [DRIVE_W-1:0]    out_right_reg;
    logic                  out_done_reg;

    logic in_accept;
    logic out_load;

    // Ramp region decode.
    logic [RAMP_W-1:0]    r_eff;
    logic signed [NW-1:0] p_s;
    logic signed [NW-1:0] t_s;
    logic signed [NW-1:0] r_s;
    logic signed [NW-1:0] t_minus_p;
    logic signed [NW1-1:0] p_twice;
    logic signed [NW1-1:0] t_wide;
    logic                 past_end;
    logic                 end_tick;
    logic                 triangle;
    logic signed [NW-1:0] n_next;
    logic                 hold_next;

    // Multiplier and divider connections.
    logic                  mul_en;
    logic signed [MA-1:0]  mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [PRW-1:0] mul_p;
    logic signed [PW-1:0]  ramp_prod;
    logic [PW-1:0]         ramp_mag;
    logic                  div_start;
    logic                  div_busy;
    logic [PW-1:0]         div_q;
    logic signed [RPW-1:0] q_ext;

    // Correction and drive sums.
    logic signed [AW-1:0]  acc_adj;
    logic signed [AW-1:0]  acc_shift;
    logic signed [SW-1:0]  left_sum;
    logic signed [SW-1:0]  right_sum;

    // Saturate a wide signed sum to Q1.15.
    function automatic logic [DRIVE_W-1:0] sat16(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'($signed({1'b0, DRIVE_POS_LIM[DRIVE_W-2:0]}));
        lo = SW'($signed(DRIVE_NEG_LIM));
        if (v > hi)
        begin
            return DRIVE_POS_LIM;
        end
        else if (v < lo)
        begin
            return DRIVE_NEG_LIM;
        end
        return v[DRIVE_W-1:0];
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RST;
            ramp_reg   <= RAMP_RST;
            gain_reg   <= GAIN_RST;
            base_reg   <= BASE_RST;
            kp_reg     <= KP_RST;
            ki_reg     <= KI_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TARGET: target_reg <= cfg_data[TGT_W-1:0];
                REG_RAMP:   ramp_reg   <= cfg_data[RAMP_W-1:0];
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_BASE:   base_reg   <= cfg_data[BASE_W-1:0];
                REG_KP:     kp_reg     <= cfg_data[KP_W-1:0];
                REG_KI:     ki_reg     <= cfg_data[KI_W-1:0];
                default:    ;
            endcase
        end
    end

    // Ramp region: rising, holding or falling, from the stored position.
    always_comb
    begin
        r_eff     = (ramp_reg == '0) ? RAMP_W'(1) : ramp_reg;
        p_s       = NW'(pos_reg);
        t_s       = NW'(target_reg);
        r_s       = NW'(r_eff);
        t_minus_p = t_s - p_s;
        p_twice   = {p_s, 1'b0};
        t_wide    = NW1'(t_s);
        past_end  = p_s > t_s;
        end_tick  = done_reg || past_end || stop_reg;
        triangle  = {r_eff, 1'b0} >= {1'b0, target_reg};
        hold_next = 1'b0;
        if (triangle)
        begin
            n_next = (p_twice < t_wide) ? p_s : t_minus_p;
        end
        else if (p_s < r_s)
        begin
            n_next = p_s;
        end
        else if (t_minus_p <= r_s)
        begin
            n_next = t_minus_p;
        end
        else
        begin
            n_next    = t_minus_p;
            hold_next = 1'b1;
        end
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = MA'(n_reg);
        mul_b  = MB'(gain_reg);
        case (state_reg)
            S_DIFF:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(n_reg);
                mul_b  = MB'(gain_reg);
            end
            S_MULP:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(dd_reg);
                mul_b  = MB'(kp_reg);
            end
            S_MULI:
            begin
                mul_en = 1'b1;
                mul_a  = MA'(diff_reg);
                mul_b  = MB'(ki_reg);
            end
            default: ;
        endcase
    end

    rmws_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Ramp product magnitude goes to the divider; the sign is kept aside.
    assign ramp_prod = PW'(mul_p);
    assign ramp_mag  = ramp_prod[PW-1] ? (~ramp_prod + 1'b1) : ramp_prod;
    assign div_start = (state_reg == S_MULP);

    rmws_div #(
        .DIVIDEND_W (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ramp_mag),
        .divisor  (r_eff),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign q_ext = RPW'(div_q);

    // Correction rounded toward zero, then the two drive sums.
    always_comb
    begin
        acc_adj   = acc_reg + AW'({acc_reg[AW-1], acc_reg[AW-1]});
        acc_shift = acc_adj >>> 2;
        left_sum  = rb_reg - SW'(corr_reg);
        right_sum = rb_reg + SW'(corr_reg);
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = in_accept ? S_CHECK : S_IDLE;
            S_CHECK: state_next = end_tick ? S_OUT : S_DIFF;
            S_DIFF:  state_next = S_MULP;
            S_MULP:  state_next = S_MULI;
            S_MULI:  state_next = S_ACC;
            S_ACC:   state_next = S_CORR;
            S_CORR:  state_next = S_DIV;
            S_DIV:   state_next = div_busy ? S_DIV : S_RB;
            S_RB:    state_next = S_SAT;
            S_SAT:   state_next = S_OUT;
            S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: sequencer and the move state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            pos_reg        <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept && new_move)
            begin
                done_reg       <= 1'b0;
                pos_reg        <= '0;
                prev_left_reg  <= '0;
                prev_right_reg <= '0;
            end
            else if (state_reg == S_CHECK && end_tick && !done_reg)
            begin
                done_reg <= 1'b1;
                pos_reg  <= '0;
            end
            else if (state_reg == S_MULP)
            begin
                pos_reg        <= left_reg;
                prev_left_reg  <= left_reg;
                prev_right_reg <= right_reg;
            end
        end
    end

    // Datapath registers along the sequence.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            left_reg  <= left_count[CW-1:0];
            right_reg <= right_count[CW-1:0];
            stop_reg  <= stop_request;
        end
        case (state_reg)
            S_CHECK:
            begin
                n_reg         <= n_next;
                hold_reg      <= hold_next;
                res_left_reg  <= '0;
                res_right_reg <= '0;
                res_done_reg  <= 1'b1;
            end
            S_DIFF:
            begin
                dd_reg   <= ((CW+2)'(left_reg) - (CW+2)'(prev_left_reg))
                          - ((CW+2)'(right_reg) - (CW+2)'(prev_right_reg));
                diff_reg <= (CW+1)'(left_reg) - (CW+1)'(right_reg);
            end
            S_MULP:  ramp_neg_reg <= ramp_prod[PW-1];
            S_MULI:  acc_reg <= AW'(mul_p);
            S_ACC:   acc_reg <= acc_reg + AW'(mul_p);
            S_CORR:  corr_reg <= CRW'(acc_shift);
            S_DIV:
            begin
                if (hold_reg)
                begin
                    term_reg <= RPW'(gain_reg);
                end
                else
                begin
                    term_reg <= ramp_neg_reg ? -q_ext : q_ext;
                end
            end
            S_RB:    rb_reg <= SW'(term_reg) + SW'(base_reg);
            S_SAT:
            begin
                res_left_reg  <= sat16(left_sum);
                res_right_reg <= sat16(right_sum);
                res_done_reg  <= 1'b0;
            end
            default: ;
        endcase
    end

    // Output register holds a beat until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_left_reg  <= res_left_reg;
            out_right_reg <= res_right_reg;
            out_done_reg  <= res_done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = out_left_reg;
    assign right_drive = out_right_reg;
    assign move_done   = out_done_reg;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for ramped_move_with_wheel_sync_unit.
// Depends on rmws_pkg and the unit; it predicts each drive beat and compares it with the output.

module tb_top;
    import rmws_pkg::*;

    // Spare register indexes that the unit must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_val;
        logic signed [DRIVE_W-1:0] right_val;
        logic                      done_val;
    } drive_beat_t;

    // Predicts the drive beats of the unit and checks the ones it delivers.
    class drive_scoreboard;
        longint move_target, ramp_len, peak_gain, base_level, kp, ki;
        longint position, prev_l, prev_r;
        bit     done;
        drive_beat_t expected_drives[$];
        int     errors;

        function new();
            move_target = TARGET_RST;
            ramp_len    = RAMP_RST;
            peak_gain   = GAIN_RST;
            base_level  = BASE_RST;
            kp          = KP_RST;
            ki          = KI_RST;
            position    = 0;
            prev_l      = 0;
            prev_r      = 0;
            done        = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET: move_target = data[TGT_W-1:0];
                REG_RAMP:   ramp_len    = data[RAMP_W-1:0];
                REG_GAIN:   peak_gain   = data[GAIN_W-1:0];
                REG_BASE:   base_level  = data[BASE_W-1:0];
                REG_KP:     kp          = data[KP_W-1:0];
                REG_KI:     ki          = data[KI_W-1:0];
                default:    ;
            endcase
        endfunction

        function logic signed [DRIVE_W-1:0] clip16(longint v);
            if (v > 32767)
                return DRIVE_POS_LIM;
            if (v < -32768)
                return DRIVE_NEG_LIM;
            return v[DRIVE_W-1:0];
        endfunction

        // Ramp drive at position p: rising, holding at the peak unless the ramps meet, then falling.
        function longint ramp_term(longint p);
            longint r;
            longint n;
            r = (ramp_len == 0) ? 1 : ramp_len;
            if (2 * r >= move_target)
                n = (2 * p < move_target) ? p : move_target - p;
            else if (p < r)
                n = p;
            else if (move_target - p <= r)
                n = move_target - p;
            else
                return peak_gain;
            return (n * peak_gain) / r;
        endfunction

        // Works out the drive beat caused by one accepted tick.
        function void note_tick(bit nm, logic signed [31:0] l_raw,
                                logic signed [31:0] r_raw, bit st);
            longint lc;
            longint rc;
            longint ramp;
            longint corr;
            drive_beat_t beat;
            lc = l_raw;
            rc = r_raw;
            if (nm)
            begin
                done     = 1'b0;
                position = 0;
                prev_l   = 0;
                prev_r   = 0;
            end
            if (done || position > move_target || st)
            begin
                if (!done)
                begin
                    position = 0;
                    done     = 1'b1;
                end
                beat = '{left_val: '0, right_val: '0, done_val: 1'b1};
            end
            else
            begin
                ramp     = ramp_term(position);
                position = lc;
                corr     = (kp * ((lc - prev_l) - (rc - prev_r)) + ki * (lc - rc)) / 4;
                prev_l   = lc;
                prev_r   = rc;
                beat.left_val  = clip16(ramp + base_level - corr);
                beat.right_val = clip16(ramp + base_level + corr);
                beat.done_val  = 1'b0;
            end
            expected_drives.push_back(beat);
        endfunction

        // Compares one delivered drive beat with the oldest prediction.
        function void check_drive(logic signed [DRIVE_W-1:0] ld,
                                  logic signed [DRIVE_W-1:0] rd, logic md);
            drive_beat_t beat;
            if (expected_drives.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected drive beat: left %0d right %0d done %0b", ld, rd, md);
                return;
            end
            beat = expected_drives.pop_front();
            if (beat.left_val !== ld || beat.right_val !== rd || beat.done_val !== md)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected left %0d right %0d done %0b, got left %0d right %0d done %0b",
                             beat.left_val, beat.right_val, beat.done_val, ld, rd, md);
            end
        endfunction

        function int outstanding();
            return expected_drives.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    new_move = 1'b0;
    logic signed [31:0]      left_count = '0;
    logic signed [31:0]      right_count = '0;
    logic                    stop_request = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                    move_done;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    drive_scoreboard sb;
    int     burst_left = 0;
    int     stall_mode = 0;
    int     stall_left = 0;
    int     quiet_cycles = 0;
    longint cur_target = TARGET_RST;

    ramped_move_with_wheel_sync_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .new_move     (new_move),
        .left_count   (left_count),
        .right_count  (right_count),
        .stop_request (stop_request),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_drive   (left_drive),
        .right_drive  (right_drive),
        .move_done    (move_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver stall: switches between free flow, light, medium and heavy stalling.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Beat monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_drive(left_drive, right_drive, move_done);
            if (in_valid && !in_stall)
                sb.note_tick(new_move, left_count, right_count, stop_request);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one tick; bursts of random length are separated by random gaps.
    task automatic send_tick(input bit nm, input logic signed [31:0] lc,
                             input logic signed [31:0] rc, input bit st);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid     <= 1'b1;
        new_move     <= nm;
        left_count   <= lc;
        right_count  <= rc;
        stop_request <= st;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds the sender back until every predicted beat has been delivered.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Writes the whole register set, plus junk to the spare indexes.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] t, input logic [CFG_DATA_W-1:0] r,
                                input logic [CFG_DATA_W-1:0] g, input logic [CFG_DATA_W-1:0] b,
                                input logic [CFG_DATA_W-1:0] p, input logic [CFG_DATA_W-1:0] i);
        put_reg(REG_TARGET, t);
        put_reg(REG_RAMP, r);
        put_reg(REG_GAIN, g);
        put_reg(REG_BASE, b);
        put_reg(REG_KP, p);
        put_reg(REG_KI, i);
        put_reg(REG_SPARE_LO, $urandom);
        put_reg(REG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        cur_target = t[TGT_W-1:0];
    endtask

    // One well-formed move: counts grow toward the target with wheel drift, then end
    // ticks follow. A move that runs backward is aborted with a stop.
    task automatic run_move(output int n);
        longint lc;
        longint rc;
        longint drift;
        int     step_max;
        int     step;
        int     dir;
        int     w;
        int     dd;
        int     extra;
        bit     st;
        lc = 0;
        rc = 0;
        drift = 0;
        n = 0;
        step_max = cur_target / 8 + 1;
        w = step_max / 16 + 1;
        dir = ($urandom_range(0, 7) == 0) ? -1 : 1;
        send_tick(1'b1, 0, 0, 1'b0);
        n++;
        while (n < 60 && lc <= cur_target)
        begin
            step = $urandom_range(1, step_max);
            lc += dir * step;
            dd = $urandom_range(0, 2 * w);
            drift += dd - w;
            rc = lc + drift;
            st = ($urandom_range(0, 99) == 0);
            send_tick(1'b0, lc, rc, st);
            n++;
            if (st)
                break;
        end
        extra = $urandom_range(1, 3);
        for (int k = 0; k < extra; k++)
        begin
            lc += dir;
            send_tick(1'b0, lc, lc + drift,
                      (dir < 0 && k == extra - 1) || ($urandom_range(0, 15) == 0));
            n++;
        end
    endtask

    // Mostly well-formed moves, some random noise ticks, and an occasional full drain.
    task automatic run_random(input int n_items);
        int issued;
        int k;
        issued = 0;
        while (issued < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                run_move(k);
                issued += k;
            end
            else
            begin
                k = $urandom_range(1, 5);
                repeat (k)
                    send_tick($urandom_range(0, 7) == 0, $urandom, $urandom,
                              $urandom_range(0, 15) == 0);
                issued += k;
            end
            if ($urandom_range(0, 29) == 0)
                drain();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under the reset settings.
        send_tick(1'b1, 0, 0, 1'b0);
        send_tick(1'b0, 500, 480, 1'b0);
        send_tick(1'b0, 2500, 2500, 1'b0);
        send_tick(1'b0, 2600, 2700, 1'b0);
        send_tick(1'b0, -100000, 0, 1'b0);
        send_tick(1'b0, 10, 10, 1'b0);
        send_tick(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        send_tick(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        send_tick(1'b0, 5, 5, 1'b0);
        send_tick(1'b0, 0, 0, 1'b1);
        send_tick(1'b1, 0, 0, 1'b1);
        send_tick(1'b1, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        send_tick(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        send_tick(1'b0, 100, 100, 1'b1);
        send_tick(1'b1, 4879, 4879, 1'b0);
        send_tick(1'b0, 4880, 4880, 1'b0);
        send_tick(1'b0, 4881, 4881, 1'b0);
        send_tick(1'b0, 4882, 4882, 1'b0);
        send_tick(1'b1, 32'shFFFFFFFF, 32'shFFFFFFFF, 1'b1);
        drain();

        // Random phases, each under its own register settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: program_regs(2000, 0, 32767, 32767, 65535, 65535);
                1: program_regs(0, 1048575, 0, 0, 0, 0);
                2: program_regs(20000, 3000, 20000, 1000, 66, 131);
                3: program_regs(1048575, 1, 32767, 0, 300, 500);
                5: program_regs($urandom_range(100, 50000), $urandom_range(0, 30000),
                                $urandom_range(0, 32767), $urandom_range(0, 32767),
                                $urandom_range(0, 2000), $urandom_range(0, 2000));
                6: program_regs(4879, 4010, 13107, 3277, 66, 131);
                default: program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            run_random(145);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
